### hw/rtl/fae_pkg.sv
`timescale 1ns / 1ps

package fae_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int FIDX_W    = 3;
    localparam int FVAL_W    = 16;
    localparam int LIMIT_W   = 12;
    localparam int FLOW_W    = 12;
    localparam int PWM_W     = 7;
    localparam int PCTQ_W    = 15;
    localparam int COEF_W    = 16;
    localparam int PEAK_W    = 8;
    localparam int FANS_W    = 4;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 16;
    localparam int DIV_W     = 32;
    localparam int DIVR_W    = 16;
    localparam int MUL_A_W   = 31;
    localparam int MUL_B_W   = 15;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int TERM_W    = 39;
    localparam int BOUND_W   = 35;
    localparam int FLOW_SHIFT = 20;

    // divide by 100 as multiply by ceil(2^30 / 100) and shift
    localparam int RECIP_W     = 24;
    localparam int RECIP_100   = 10737419;
    localparam int RECIP_SHIFT = 30;

    localparam int MAX_FANS_DEF = 8;

    // constants
    localparam int PCT_FULL  = 100;
    localparam int MIN_FLOW  = 50;
    localparam int FLOW_SAT  = 4095;
    localparam int PCT_Q_MAX = 32767;
    localparam int PCT_Q_FULL = 25600;

    // opcodes
    localparam logic [OP_W-1:0] OP_SPEED = 2'd0;
    localparam logic [OP_W-1:0] OP_FULL  = 2'd1;
    localparam logic [OP_W-1:0] OP_LIMIT = 2'd2;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_FANS     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_COEF_LO  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_COEF_HI  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_PCT_MIN  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_PCT_MAX  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_PEAK     = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_AF_CHECK, S_PCT_DIV, S_COEF, S_INTERP_MUL,
        S_INTERP_DIV, S_MUL_CP, S_MUL_PCT, S_ACC, S_MUL_N, S_CMP,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        DV_PCT, DV_COEF
    } t_div_sel;

    typedef enum logic [2:0] {
        MS_DIFF_OFF, MS_COEF_PEAK, MS_PROD_PCT, MS_PROD_PWM, MS_PROD_N
    } t_mul_sel;

    typedef struct packed {
        logic     in_take;
        logic     af_init;
        logic     idx_inc;
        logic     div_start;
        t_div_sel div_sel;
        logic     pct_load;
        logic     coef_load_sel;
        logic     coef_load_div;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_add;
        logic     flow_load;
        logic     flow_invalid;
        logic     lim_none;
        logic     lim_reject;
        logic     lim_start;
        logic     pwm_dec;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            lim_zero;
        logic            lim_low;
        logic            idx_done;
        logic            cur_seen;
        logic            cur_fs_bad;
        logic            need_interp;
        logic            div_done;
        logic            flow_ok;
        logic            pwm_zero;
    } t_stat;

endpackage

### hw/rtl/fae_div.sv
`timescale 1ns / 1ps

module fae_div
    import fae_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [DIVR_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(DIV_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_dq, n_dq;
    logic [DIVR_W-1:0] r_rem, n_rem;
    logic [DIVR_W-1:0] r_div, n_div;
    logic [DIVR_W:0]   w_trial;

    // one quotient bit per cycle, restoring
    always_comb begin
        w_trial = {r_rem, r_dq[DIV_W-1]};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_dq    = r_dq;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dq   = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = DIVR_W'(w_trial - {1'b0, r_div});
                n_dq  = {r_dq[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DIVR_W-1:0];
                n_dq  = {r_dq[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dq  <= n_dq;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_dq;

endmodule

### hw/rtl/fae_datapath.sv
`timescale 1ns / 1ps

module fae_datapath
    import fae_pkg::*;
#(
    parameter int MAX_FANS = MAX_FANS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [OP_W-1:0]    i_op,
    input  logic [FIDX_W-1:0]  i_fan_index,
    input  logic [FVAL_W-1:0]  i_fan_value,
    input  logic [LIMIT_W-1:0] i_flow_limit,
    input  logic               i_cfg_we,
    input  logic [CFG_AW-1:0]  i_cfg_addr,
    input  logic [CFG_DW-1:0]  i_cfg_data,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic               o_res_kind,
    output logic [FLOW_W-1:0]  o_res_airflow,
    output logic               o_res_valid,
    output logic [PWM_W-1:0]   o_res_pwm,
    output logic               o_res_rej
);

    localparam int IW    = (MAX_FANS > 1) ? $clog2(MAX_FANS) : 1;
    localparam int NW    = $clog2(MAX_FANS + 1);
    localparam int ACC_W = TERM_W + $clog2(MAX_FANS) + 1;
    localparam int FQ_W  = ACC_W - FLOW_SHIFT;
    localparam int RP_W  = FQ_W + RECIP_W;
    localparam int RQ_W  = RP_W - RECIP_SHIFT;

    // configuration
    logic [FANS_W-1:0]  r_fans;
    logic [COEF_W-1:0]  r_coef_lo, r_coef_hi;
    logic [PWM_W-1:0]   r_pct_min, r_pct_max;
    logic [PEAK_W-1:0]  r_peak;

    // per-fan state
    logic [FVAL_W-1:0]  r_speed [MAX_FANS];
    logic [FVAL_W-1:0]  r_full  [MAX_FANS];
    logic [MAX_FANS-1:0] r_speed_seen, r_full_seen;

    // working registers
    logic [OP_W-1:0]    r_op;
    logic [LIMIT_W-1:0] r_limit;
    logic [BOUND_W-1:0] r_bound;
    logic [NW-1:0]      r_idx;
    logic [PCTQ_W-1:0]  r_pct;
    logic [COEF_W-1:0]  r_coef;
    logic [PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]   r_acc;
    logic               r_kind;
    logic [FLOW_W-1:0]  r_airflow;
    logic               r_af_valid;
    logic [PWM_W-1:0]   r_pwm;
    logic               r_rej;
    logic               r_o_kind, r_o_valid, r_o_rej;
    logic [FLOW_W-1:0]  r_o_airflow;
    logic [PWM_W-1:0]   r_o_pwm;

    logic [NW-1:0]      w_n_act;
    logic [IW-1:0]      w_ridx;
    logic [PCTQ_W-1:0]  w_lo, w_hi;
    logic [COEF_W-1:0]  w_diff, w_coef_sel;
    logic               w_need_interp;
    logic               w_up;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic               w_div_start;
    logic [DIV_W-1:0]   w_dividend, w_quot;
    logic [DIVR_W-1:0]  w_divisor;
    logic               w_div_done;
    logic               w_in_range;
    logic [FQ_W-1:0]    w_flow_x;
    logic [RP_W-1:0]    w_flow_p;
    logic [RQ_W-1:0]    w_flow_q;

    assign w_n_act = (32'(r_fans) > MAX_FANS) ? NW'(MAX_FANS) : NW'(r_fans);
    assign w_ridx  = r_idx[IW-1:0];
    assign w_lo    = {r_pct_min, 8'b0};
    assign w_hi    = {r_pct_max, 8'b0};
    assign w_up    = (r_coef_hi >= r_coef_lo);
    assign w_diff  = w_up ? (r_coef_hi - r_coef_lo) : (r_coef_lo - r_coef_hi);
    assign w_in_range = (32'(i_fan_index) < MAX_FANS);

    // sum over 100 * 2^20: shift, then reciprocal multiply
    assign w_flow_x = r_acc[ACC_W-1:FLOW_SHIFT];
    assign w_flow_p = RP_W'(w_flow_x) * RP_W'(RECIP_100);
    assign w_flow_q = w_flow_p[RP_W-1:RECIP_SHIFT];

    // coefficient pick outside the interpolation span
    always_comb begin
        w_coef_sel = r_coef_lo;
        w_need_interp = 1'b0;
        priority if (r_pct == '0) begin
            w_coef_sel = '0;
        end else if (r_pct < w_lo) begin
            w_coef_sel = r_coef_lo;
        end else if (r_pct > w_hi) begin
            w_coef_sel = r_coef_hi;
        end else if (w_hi <= w_lo) begin
            w_coef_sel = r_coef_lo;
        end else begin
            w_need_interp = 1'b1;
        end
    end

    always_comb begin
        o_stat.op          = r_op;
        o_stat.lim_zero    = (r_limit == '0);
        o_stat.lim_low     = (r_limit < LIMIT_W'(MIN_FLOW));
        o_stat.idx_done    = (r_idx >= w_n_act);
        o_stat.cur_seen    = r_speed_seen[w_ridx];
        o_stat.cur_fs_bad  = !r_full_seen[w_ridx] || (r_full[w_ridx] == '0);
        o_stat.need_interp = w_need_interp;
        o_stat.div_done    = w_div_done;
        o_stat.flow_ok     = (r_prod <= PROD_W'(r_bound));
        o_stat.pwm_zero    = (r_pwm == '0);
    end

    // shared multiplier operands
    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_DIFF_OFF: begin
                w_mul_a = MUL_A_W'(w_diff);
                w_mul_b = r_pct - w_lo;
            end
            MS_COEF_PEAK: begin
                w_mul_a = MUL_A_W'(r_coef);
                w_mul_b = MUL_B_W'(r_peak);
            end
            MS_PROD_PCT: begin
                w_mul_a = MUL_A_W'(r_prod[23:0]);
                w_mul_b = r_pct;
            end
            MS_PROD_PWM: begin
                w_mul_a = r_prod[MUL_A_W-1:0];
                w_mul_b = MUL_B_W'(r_pwm);
            end
            MS_PROD_N: begin
                w_mul_a = r_prod[MUL_A_W-1:0];
                w_mul_b = MUL_B_W'(w_n_act);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // shared divider operands
    always_comb begin
        w_div_start = i_cmd.div_start;
        unique case (i_cmd.div_sel)
            DV_PCT: begin
                w_dividend = DIV_W'(r_speed[w_ridx]) * DIV_W'(PCT_Q_FULL);
                w_divisor  = r_full[w_ridx];
            end
            DV_COEF: begin
                w_dividend = r_prod[DIV_W-1:0];
                w_divisor  = DIVR_W'(w_hi - w_lo);
            end
            default: begin
                w_dividend = '0;
                w_divisor  = '0;
            end
        endcase
    end

    fae_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // configuration and seen flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fans       <= FANS_W'(1);
            r_coef_lo    <= '0;
            r_coef_hi    <= '0;
            r_pct_min    <= '0;
            r_pct_max    <= PWM_W'(PCT_FULL);
            r_peak       <= '0;
            r_speed_seen <= '0;
            r_full_seen  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_FANS:    r_fans    <= i_cfg_data[FANS_W-1:0];
                    REG_COEF_LO: r_coef_lo <= i_cfg_data[COEF_W-1:0];
                    REG_COEF_HI: r_coef_hi <= i_cfg_data[COEF_W-1:0];
                    REG_PCT_MIN: r_pct_min <= i_cfg_data[PWM_W-1:0];
                    REG_PCT_MAX: r_pct_max <= i_cfg_data[PWM_W-1:0];
                    REG_PEAK:    r_peak    <= i_cfg_data[PEAK_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.in_take && w_in_range) begin
                if (i_op == OP_SPEED) r_speed_seen[IW'(i_fan_index)] <= 1'b1;
                if (i_op == OP_FULL)  r_full_seen[IW'(i_fan_index)]  <= 1'b1;
            end
        end
    end

    // stores and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            if (w_in_range && i_op == OP_SPEED) r_speed[IW'(i_fan_index)] <= i_fan_value;
            if (w_in_range && i_op == OP_FULL)  r_full[IW'(i_fan_index)]  <= i_fan_value;
            r_op       <= i_op;
            r_limit    <= i_flow_limit;
            r_bound    <= {BOUND_W'(i_flow_limit) * BOUND_W'(PCT_FULL)} << 16;
            r_kind     <= (i_op == OP_LIMIT);
            r_airflow  <= '0;
            r_af_valid <= 1'b0;
            r_pwm      <= '0;
            r_rej      <= 1'b0;
        end
        if (i_cmd.af_init) begin
            r_idx <= '0;
            r_acc <= '0;
        end
        if (i_cmd.idx_inc) r_idx <= r_idx + 1'b1;
        if (i_cmd.pct_load) begin
            r_pct <= (w_quot > DIV_W'(PCT_Q_MAX)) ? PCTQ_W'(PCT_Q_MAX) : w_quot[PCTQ_W-1:0];
        end
        if (i_cmd.coef_load_sel) r_coef <= w_coef_sel;
        if (i_cmd.coef_load_div) begin
            r_coef <= w_up ? (r_coef_lo + w_quot[COEF_W-1:0])
                           : (r_coef_lo - w_quot[COEF_W-1:0]);
        end
        if (i_cmd.mul_en) r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        if (i_cmd.acc_add) r_acc <= r_acc + ACC_W'(r_prod[TERM_W-1:0]);
        if (i_cmd.flow_load) begin
            r_airflow  <= (w_flow_q > RQ_W'(FLOW_SAT)) ? FLOW_W'(FLOW_SAT)
                                                       : w_flow_q[FLOW_W-1:0];
            r_af_valid <= 1'b1;
        end
        if (i_cmd.flow_invalid) begin
            r_airflow  <= '0;
            r_af_valid <= 1'b0;
        end
        if (i_cmd.lim_none) r_pwm <= PWM_W'(PCT_FULL);
        if (i_cmd.lim_reject) begin
            r_pwm <= '0;
            r_rej <= 1'b1;
        end
        if (i_cmd.lim_start) begin
            r_pwm <= PWM_W'(PCT_FULL);
            r_pct <= PCTQ_W'(PCT_Q_FULL);
        end
        if (i_cmd.pwm_dec) begin
            r_pwm <= r_pwm - 1'b1;
            r_pct <= {r_pwm - 1'b1, 8'b0};
        end
        if (i_cmd.out_load) begin
            r_o_kind    <= r_kind;
            r_o_airflow <= r_airflow;
            r_o_valid   <= r_af_valid;
            r_o_pwm     <= r_pwm;
            r_o_rej     <= r_rej;
        end
    end

    assign o_res_kind    = r_o_kind;
    assign o_res_airflow = r_o_airflow;
    assign o_res_valid   = r_o_valid;
    assign o_res_pwm     = r_o_pwm;
    assign o_res_rej     = r_o_rej;

endmodule

### hw/rtl/fae_ctrl.sv
`timescale 1ns / 1ps

module fae_ctrl
    import fae_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_search, n_search;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state  = r_state;
        n_search = r_search;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                if (i_stat.op == OP_LIMIT) begin
                    n_search = 1'b1;
                    priority if (i_stat.lim_zero) n_state = S_FINISH;
                    else if (i_stat.lim_low)      n_state = S_FINISH;
                    else                          n_state = S_COEF;
                end else begin
                    n_search = 1'b0;
                    n_state  = S_AF_CHECK;
                end
            end
            S_AF_CHECK: begin
                priority if (i_stat.idx_done)   n_state = S_FINISH;
                else if (!i_stat.cur_seen)      n_state = S_AF_CHECK;
                else if (i_stat.cur_fs_bad)     n_state = S_FINISH;
                else                            n_state = S_PCT_DIV;
            end
            S_PCT_DIV:    if (i_stat.div_done) n_state = S_COEF;
            S_COEF:       n_state = i_stat.need_interp ? S_INTERP_MUL : S_MUL_CP;
            S_INTERP_MUL: n_state = S_INTERP_DIV;
            S_INTERP_DIV: if (i_stat.div_done) n_state = S_MUL_CP;
            S_MUL_CP:     n_state = S_MUL_PCT;
            S_MUL_PCT:    n_state = r_search ? S_MUL_N : S_ACC;
            S_ACC:        n_state = S_AF_CHECK;
            S_MUL_N:      n_state = S_CMP;
            S_CMP: begin
                if (i_stat.flow_ok || i_stat.pwm_zero) n_state = S_FINISH;
                else                                   n_state = S_COEF;
            end
            S_FINISH:     if (w_out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        o_cmd.div_sel = DV_PCT;
        o_cmd.mul_sel = MS_COEF_PEAK;
        unique case (r_state)
            S_IDLE: o_cmd.in_take = i_in_valid;
            S_DECODE: begin
                if (i_stat.op == OP_LIMIT) begin
                    priority if (i_stat.lim_zero) o_cmd.lim_none = 1'b1;
                    else if (i_stat.lim_low)      o_cmd.lim_reject = 1'b1;
                    else                          o_cmd.lim_start = 1'b1;
                end else begin
                    o_cmd.af_init = 1'b1;
                end
            end
            S_AF_CHECK: begin
                priority if (i_stat.idx_done) begin
                    o_cmd.flow_load = 1'b1;
                end else if (!i_stat.cur_seen) begin
                    o_cmd.idx_inc = 1'b1;
                end else if (i_stat.cur_fs_bad) begin
                    o_cmd.flow_invalid = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DV_PCT;
                end
            end
            S_PCT_DIV: o_cmd.pct_load = i_stat.div_done;
            S_COEF: begin
                if (i_stat.need_interp) begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = MS_DIFF_OFF;
                end else begin
                    o_cmd.coef_load_sel = 1'b1;
                end
            end
            S_INTERP_MUL: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DV_COEF;
            end
            S_INTERP_DIV: o_cmd.coef_load_div = i_stat.div_done;
            S_MUL_CP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_COEF_PEAK;
            end
            S_MUL_PCT: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = r_search ? MS_PROD_PWM : MS_PROD_PCT;
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            S_MUL_N: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_PROD_N;
            end
            S_CMP: o_cmd.pwm_dec = !(i_stat.flow_ok || i_stat.pwm_zero);
            S_FINISH: o_cmd.out_load = w_out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load)   n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_search    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_search    <= n_search;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/fan_airflow_estimator_unit.sv
`timescale 1ns / 1ps

// fan airflow estimator: keeps per-fan tach speed and full-scale rpm and
// answers each request with one result. speed (opcode 0) and full-scale
// (opcode 1) requests update the fan and return total airflow in sixteenths
// of a cfm, saturated at 4095, flagged invalid when a fan with a speed lacks a
// nonzero full scale. opcode 2 takes an airflow limit in whole cfm and
// returns the highest pwm percent whose modeled flow stays within it; a
// limit of 0 gives 100, a limit from 1 to 49 is rejected. one request is
// worked at a time; the percent and interpolation divides go through one
// shared radix-2 divider, and the final divide by 100 is a reciprocal
// multiply. an airflow request walks the counted fans: it skips a fan
// without a speed and, for a fan with one, divides for its percent, picks
// or interpolates the coefficient (one more divide inside the span) and
// adds its term. a limit search steps the pwm down from 100, at most 101
// steps, modeling the flow at each. the finishing state waits while the
// previous result is still held. a new request is taken while a finished
// result still waits on the output register. configuration registers must
// be written through the plain write port only while no request is in
// flight; the block itself does not enforce it.

module fan_airflow_estimator_unit
    import fae_pkg::*;
#(
    parameter int MAX_FANS = MAX_FANS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // fan_index[2:0], fan_value[18:3], flow_limit[30:19]
    input  logic [OP_W-1:0]   s_axis_tuser,   // opcode
    // result channel
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // airflow[11:0], airflow_valid[12],
                                              // pwm_percent[19:13], limit_rejected[20]
    output logic              m_axis_tuser,   // result_kind
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic              w_kind, w_valid, w_rej;
    logic [FLOW_W-1:0] w_airflow;
    logic [PWM_W-1:0]  w_pwm;

    // sequencer
    fae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // fan stores, shared multiplier and divider, output register
    fae_datapath #(
        .MAX_FANS (MAX_FANS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (s_axis_tuser),
        .i_fan_index   (s_axis_tdata[2:0]),
        .i_fan_value   (s_axis_tdata[18:3]),
        .i_flow_limit  (s_axis_tdata[30:19]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_res_kind    (w_kind),
        .o_res_airflow (w_airflow),
        .o_res_valid   (w_valid),
        .o_res_pwm     (w_pwm),
        .o_res_rej     (w_rej)
    );

    // pack the result, pad to whole bytes
    assign m_axis_tdata = {3'b000, w_rej, w_pwm, w_valid, w_airflow};
    assign m_axis_tuser = w_kind;

endmodule

### hw/rtl/fae_checker.sv
`timescale 1ns / 1ps

module fae_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // limit result carries no airflow
    a_limit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[11:0] == 12'd0 && !m_axis_tdata[12] && m_axis_tdata[19:13] <= 7'd100)
        else $error("bad limit result fields");

    // airflow result carries no pwm
    a_flow_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[19:13] == 7'd0 && !m_axis_tdata[20])
        else $error("bad airflow result fields");

    // rejected limit gives zero pwm
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[20] |-> m_axis_tdata[19:13] == 7'd0)
        else $error("rejected limit with nonzero pwm");

    // invalid airflow reads as zero
    a_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser && !m_axis_tdata[12] |-> m_axis_tdata[11:0] == 12'd0)
        else $error("invalid airflow not zero");

endmodule

bind fan_airflow_estimator_unit fae_checker u_fae_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
